/* rtl/core/pba_pkg.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator package
// Shared constants and action codes.
// ----------------------------------------------------------------------------
package pba_pkg;

    localparam int unsigned NUM_PAGES_DEF  = 4096;
    localparam int unsigned PAGE_SHIFT_DEF = 12;
    localparam logic [31:0] HEAP_BASE_RST  = 32'h0010_0000;
    localparam logic [24:0] USED_MAX       = 25'h1FF_FFFF;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_QUERY = 2'd2;

endpackage

/* rtl/core/page_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator top level
// First-fit page allocator over a one-bit-per-page used map held in memory.
// ----------------------------------------------------------------------------
// After reset a clearing pass writes zero to every map word, one word a cycle,
// while s_ready stays low. Each item that is not finished at once then walks
// the map one bit a cycle, pausing at each map word boundary to read the word
// from the memory: an allocate scans from page 0 until the run fits or the
// map ends and then writes a fitting run back from its first page; a free
// walks the freed pages; a query walks the whole map. Each registered memory
// read passes through a read state and a wait state before the word is used.
// A result waits in an output register while the next item is held off.
// ----------------------------------------------------------------------------
module page_bitmap_allocator_top #(
    parameter int unsigned NUM_PAGES  = pba_pkg::NUM_PAGES_DEF,
    parameter int unsigned PAGE_SHIFT = pba_pkg::PAGE_SHIFT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [12:0] s_page_count,
    input  logic [31:0] s_address,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [31:0] m_alloc_address,
    output logic        m_ok,
    output logic [24:0] m_used_bytes
);

    localparam int unsigned WORDS = (NUM_PAGES + 31) / 32;
    localparam int unsigned AW    = (WORDS > 1) ? $clog2(WORDS) : 1;
    localparam int unsigned PW    = $clog2(NUM_PAGES + 1);

    typedef enum logic [3:0] {
        ST_CLEAR, ST_IDLE, ST_RD, ST_WAIT, ST_SCAN, ST_MRD, ST_MWAIT, ST_MARK,
        ST_FRD, ST_FWAIT, ST_FCLR, ST_DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] heap_base_reg;
    logic [1:0]  act_reg;
    logic [PW-1:0] count_reg, run_reg, page_reg, left_reg;
    logic [PW-1:0] used_reg;
    logic [31:0] word_reg;
    logic [AW-1:0] clr_reg;
    logic [31:0] out_addr_reg;
    logic        out_ok_reg, m_valid_reg;
    logic [24:0] out_used_reg;

    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [31:0]   wdata, rdata;

    pba_map_ram #(.WORDS(WORDS), .AW(AW)) u_ram (
        .aclk(aclk), .we(we), .waddr(waddr), .wdata(wdata),
        .raddr(raddr), .rdata(rdata)
    );

    // Page decode helpers.
    logic [AW-1:0] page_word;
    logic [4:0]    page_bit;
    logic          cur_bit;
    assign page_word = AW'(page_reg >> 5);
    assign page_bit  = page_reg[4:0];
    assign cur_bit   = word_reg[page_bit];

    // Free range check, reckoned in 33 bits.
    logic [32:0] heap_limit;
    logic        in_range;
    logic [31:0] off;
    assign heap_limit = {1'b0, heap_base_reg} + (33'(NUM_PAGES) << PAGE_SHIFT);
    assign in_range = ({1'b0, s_address} >= {1'b0, heap_base_reg})
                   && ({1'b0, s_address} < heap_limit);
    assign off      = s_address - heap_base_reg;

    // Requested count, clamped to the map size.
    logic          count_fits;
    logic [PW-1:0] count_lim;
    assign count_fits = (32'(s_page_count) <= NUM_PAGES);
    assign count_lim  = count_fits ? PW'(s_page_count) : PW'(NUM_PAGES);

    assign s_ready = (state_reg == ST_IDLE) && !m_valid_reg;
    assign m_valid = m_valid_reg;
    assign m_alloc_address = out_addr_reg;
    assign m_ok = out_ok_reg;
    assign m_used_bytes = out_used_reg;

    // Memory port drive.
    always_comb begin
        we    = 1'b0;
        waddr = page_word;
        wdata = word_reg;
        raddr = page_word;
        if (state_reg == ST_CLEAR) begin
            we    = 1'b1;
            waddr = clr_reg;
            wdata = '0;
        end else if (state_reg == ST_MARK || state_reg == ST_FCLR) begin
            if (page_bit == 5'd31 || left_reg == PW'(1)
                    || page_reg == PW'(NUM_PAGES - 1)) begin
                we    = 1'b1;
                wdata = word_reg;
                wdata[page_bit] = (state_reg == ST_MARK);
            end
        end
    end

    // Sequencer.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_CLEAR;
            clr_reg       <= '0;
            heap_base_reg <= pba_pkg::HEAP_BASE_RST;
            m_valid_reg   <= 1'b0;
        end else begin
            if (cfg_we) begin
                heap_base_reg <= cfg_wdata;
            end
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_CLEAR: begin
                    clr_reg <= clr_reg + 1'b1;
                    if (clr_reg == AW'(WORDS - 1)) begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE: begin
                    if (s_valid && s_ready) begin
                        act_reg      <= s_action;
                        count_reg    <= count_lim;
                        left_reg     <= count_lim;
                        run_reg      <= '0;
                        used_reg     <= '0;
                        page_reg     <= (s_action == pba_pkg::ACT_FREE)
                                        ? PW'(off >> PAGE_SHIFT) : '0;
                        out_addr_reg <= '0;
                        out_ok_reg   <= (s_action == pba_pkg::ACT_FREE) && in_range;
                        out_used_reg <= '0;
                        case (s_action)
                            pba_pkg::ACT_ALLOC: begin
                                state_reg <= (s_page_count != '0 && count_fits)
                                             ? ST_RD : ST_DONE;
                            end
                            pba_pkg::ACT_FREE: begin
                                state_reg <= (in_range && s_page_count != '0)
                                             ? ST_FRD : ST_DONE;
                            end
                            pba_pkg::ACT_QUERY: state_reg <= ST_RD;
                            default: state_reg <= ST_DONE;
                        endcase
                    end
                end
                ST_RD:    state_reg <= ST_WAIT;
                ST_WAIT: begin
                    word_reg  <= rdata;
                    state_reg <= ST_SCAN;
                end
                ST_SCAN: begin
                    // One page per cycle; fetch the next word at a boundary.
                    if (act_reg == pba_pkg::ACT_QUERY) begin
                        used_reg <= used_reg + PW'(cur_bit);
                        if (page_reg == PW'(NUM_PAGES - 1)) begin
                            state_reg <= ST_DONE;
                            if ((33'(used_reg) + 33'(cur_bit)) << PAGE_SHIFT
                                    > 33'(pba_pkg::USED_MAX)) begin
                                out_used_reg <= pba_pkg::USED_MAX;
                            end else begin
                                out_used_reg <= 25'((32'(used_reg) + 32'(cur_bit))
                                                    << PAGE_SHIFT);
                            end
                        end else begin
                            page_reg <= page_reg + 1'b1;
                            if (page_bit == 5'd31) state_reg <= ST_RD;
                        end
                    end else begin
                        if (!cur_bit && run_reg + 1'b1 == count_reg) begin
                            page_reg  <= page_reg + 1'b1 - count_reg;
                            left_reg  <= count_reg;
                            out_ok_reg   <= 1'b1;
                            out_addr_reg <= heap_base_reg + 32'(
                                {32'b0, page_reg + 1'b1 - count_reg} << PAGE_SHIFT);
                            state_reg <= ST_MRD;
                        end else if (page_reg == PW'(NUM_PAGES - 1)) begin
                            state_reg <= ST_DONE;
                        end else begin
                            run_reg  <= cur_bit ? '0 : run_reg + 1'b1;
                            page_reg <= page_reg + 1'b1;
                            if (page_bit == 5'd31) state_reg <= ST_RD;
                        end
                    end
                end
                ST_MRD:   state_reg <= ST_MWAIT;
                ST_MWAIT: begin
                    word_reg  <= rdata;
                    state_reg <= ST_MARK;
                end
                ST_MARK, ST_FCLR: begin
                    word_reg[page_bit] <= (state_reg == ST_MARK);
                    if (left_reg == PW'(1) || page_reg == PW'(NUM_PAGES - 1)) begin
                        state_reg <= ST_DONE;
                    end else begin
                        left_reg <= left_reg - 1'b1;
                        page_reg <= page_reg + 1'b1;
                        if (page_bit == 5'd31) begin
                            state_reg <= (state_reg == ST_MARK) ? ST_MRD : ST_FRD;
                        end
                    end
                end
                ST_FRD:   state_reg <= ST_FWAIT;
                ST_FWAIT: begin
                    word_reg  <= rdata;
                    state_reg <= ST_FCLR;
                end
                ST_DONE: begin
                    m_valid_reg <= 1'b1;
                    state_reg   <= ST_IDLE;
                end
                default: state_reg <= ST_IDLE;
            endcase
        end
    end

    // A result is only raised when no item is in flight.
    assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) |-> $past(state_reg) == ST_DONE)
        else $error("result raised outside completion");
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> !m_valid)
        else $error("input taken with result pending");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_alloc_address != '0 |-> m_ok)
        else $error("address without success");
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_used_bytes != '0 |-> !m_ok)
        else $error("query result with ok set");

endmodule

/* rtl/core/pba_map_ram.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator map memory
// One-port-write, one-port-read word memory with registered read data.
// ----------------------------------------------------------------------------
module pba_map_ram #(
    parameter int unsigned WORDS = 128,
    parameter int unsigned AW    = 7
) (
    input  logic          aclk,
    input  logic          we,
    input  logic [AW-1:0] waddr,
    input  logic [31:0]   wdata,
    input  logic [AW-1:0] raddr,
    output logic [31:0]   rdata
);

    logic [31:0] mem [WORDS];

    // Write port.
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port.
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

/* dv/pba_checker.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator checker
// Watches the configuration port and both item channels. Each accepted input
// item is run through a local first-fit allocator that keeps its own page map
// and heap base. Each accepted result is compared field by field with the
// oldest outstanding expectation.
// ----------------------------------------------------------------------------
module pba_checker (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    input  logic        s_ready,
    input  logic [1:0]  s_action,
    input  logic [12:0] s_page_count,
    input  logic [31:0] s_address,
    input  logic        m_valid,
    input  logic        m_ready,
    input  logic [31:0] m_alloc_address,
    input  logic        m_ok,
    input  logic [24:0] m_used_bytes,
    output int unsigned fail_count,
    output int unsigned pending
);

    localparam int unsigned PAGES = pba_pkg::NUM_PAGES_DEF;
    localparam int unsigned SHIFT = pba_pkg::PAGE_SHIFT_DEF;

    typedef struct packed {
        logic [31:0] alloc_address;
        logic        ok;
        logic [24:0] used_bytes;
    } alloc_result_t;

    logic [PAGES-1:0] page_used;
    logic [31:0]      heap_base;
    alloc_result_t    expected_results[$];

    assign pending = expected_results.size();

    // First-fit allocator: updates the local page map and returns the result.
    function automatic alloc_result_t serve_request(logic [1:0] action,
                                                    logic [12:0] count,
                                                    logic [31:0] addr);
        alloc_result_t res;
        int unsigned   run;
        int unsigned   first;
        int unsigned   idx;
        int unsigned   used;
        logic [32:0]   heap_limit;
        logic [63:0]   bytes;
        res = '0;
        case (action)
            pba_pkg::ACT_ALLOC: begin
                run = 0;
                if (count != 0) begin
                    for (int unsigned i = 0; i < PAGES; i++) begin
                        if (page_used[i]) begin
                            run = 0;
                        end else begin
                            run++;
                            if (run == count) begin
                                first = i + 1 - count;
                                for (int unsigned k = first; k <= i; k++)
                                    page_used[k] = 1'b1;
                                res.alloc_address = heap_base + 32'(first << SHIFT);
                                res.ok = 1'b1;
                                break;
                            end
                        end
                    end
                end
            end
            pba_pkg::ACT_FREE: begin
                heap_limit = {1'b0, heap_base} + (33'(PAGES) << SHIFT);
                if ({1'b0, addr} >= {1'b0, heap_base} && {1'b0, addr} < heap_limit) begin
                    idx = (addr - heap_base) >> SHIFT;
                    for (int unsigned i = 0; i < count && idx + i < PAGES; i++)
                        page_used[idx + i] = 1'b0;
                    res.ok = 1'b1;
                end
            end
            pba_pkg::ACT_QUERY: begin
                used = 0;
                for (int unsigned i = 0; i < PAGES; i++)
                    used += page_used[i];
                bytes = 64'(used) << SHIFT;
                res.used_bytes = (bytes > 64'(pba_pkg::USED_MAX)) ? pba_pkg::USED_MAX
                                                                 : bytes[24:0];
            end
            default: begin
                res = '0;
            end
        endcase
        return res;
    endfunction

    // Predict on input acceptance, compare on result acceptance.
    always @(posedge aclk) begin
        alloc_result_t exp_res;
        if (!aresetn) begin
            page_used = '0;
            heap_base = pba_pkg::HEAP_BASE_RST;
            expected_results.delete();
            fail_count = 0;
        end else begin
            if (cfg_we)
                heap_base = cfg_wdata;
            if (s_valid && s_ready)
                expected_results.push_back(serve_request(s_action, s_page_count,
                                                         s_address));
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("result item with no request outstanding:",
                                 " addr %h ok %b used %h",
                                 m_alloc_address, m_ok, m_used_bytes);
                end else begin
                    exp_res = expected_results.pop_front();
                    if (exp_res.alloc_address !== m_alloc_address || exp_res.ok !== m_ok ||
                        exp_res.used_bytes !== m_used_bytes) begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("mismatch: expected addr %h ok %b used %h,",
                                     exp_res.alloc_address, exp_res.ok,
                                     exp_res.used_bytes,
                                     " got addr %h ok %b used %h",
                                     m_alloc_address, m_ok, m_used_bytes);
                    end
                end
            end
        end
    end

endmodule

/* dv/tb_page_bitmap_allocator_top.sv */
// ----------------------------------------------------------------------------
// Page bitmap allocator testbench
// Drives directed and random allocate, free and query items under several
// heap base settings and varying idle patterns on both channels; the checker
// predicts and compares every result.
// ----------------------------------------------------------------------------
module tb_page_bitmap_allocator_top;

    localparam logic [1:0]  ACT_NONE   = 2'd3;
    localparam int unsigned WDOG_LIMIT = 200000;
    localparam int unsigned RAND_ITEMS = 1500;

    logic        aclk;
    logic        aresetn;
    logic        cfg_we;
    logic [31:0] cfg_wdata;
    logic        s_valid;
    logic        s_ready;
    logic [1:0]  s_action;
    logic [12:0] s_page_count;
    logic [31:0] s_address;
    logic        m_valid;
    logic        m_ready;
    logic [31:0] m_alloc_address;
    logic        m_ok;
    logic [24:0] m_used_bytes;
    int unsigned fail_count;
    int unsigned pending;
    int unsigned tx_idle_pct;
    int unsigned rx_idle_pct;
    int unsigned quiet_cycles;
    logic [31:0] heap_base;

    page_bitmap_allocator_top dut (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_page_count(s_page_count), .s_address(s_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_alloc_address(m_alloc_address),
        .m_ok(m_ok), .m_used_bytes(m_used_bytes)
    );

    pba_checker u_checker (
        .aclk(aclk), .aresetn(aresetn), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_valid(s_valid), .s_ready(s_ready), .s_action(s_action),
        .s_page_count(s_page_count), .s_address(s_address),
        .m_valid(m_valid), .m_ready(m_ready), .m_alloc_address(m_alloc_address),
        .m_ok(m_ok), .m_used_bytes(m_used_bytes),
        .fail_count(fail_count), .pending(pending)
    );

    // Clock generation.
    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // Receiver back-pressure, changed on the falling edge.
    initial m_ready = 1'b0;
    always @(negedge aclk) begin
        m_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog on cycles with no item accepted on either channel.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WDOG_LIMIT) begin
                $display("page_bitmap_allocator_top regression: fail");
                $finish;
            end
        end
    end

    // Presents one item and returns at the falling edge after it is accepted.
    task automatic send_item(logic [1:0] action, logic [12:0] count, logic [31:0] addr);
        while ($urandom_range(0, 99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid      <= 1'b1;
        s_action     <= action;
        s_page_count <= count;
        s_address    <= addr;
        @(posedge aclk);
        while (!s_ready)
            @(posedge aclk);
        @(negedge aclk);
    endtask

    // Lets every result drain, then writes the heap base.
    task automatic set_heap_base(logic [31:0] value);
        s_valid <= 1'b0;
        @(negedge aclk);
        while (pending != 0)
            @(negedge aclk);
        repeat (4) @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        heap_base  = value;
        @(negedge aclk);
        cfg_we    <= 1'b0;
        @(negedge aclk);
    endtask

    // One random item, mostly well-formed allocate/free/query traffic.
    task automatic send_random_item();
        int unsigned sel;
        logic [12:0] count;
        logic [31:0] addr;
        sel  = $urandom_range(0, 99);
        addr = $urandom;
        if (sel < 40) begin
            count = ($urandom_range(0, 19) == 0) ? 13'($urandom_range(0, 8191))
                                                 : 13'($urandom_range(1, 32));
            send_item(pba_pkg::ACT_ALLOC, count, addr);
        end else if (sel < 75) begin
            if ($urandom_range(0, 19) != 0) begin
                addr = heap_base + ($urandom_range(0, 4095) << pba_pkg::PAGE_SHIFT_DEF);
                if ($urandom_range(0, 9) == 0)
                    addr = addr + $urandom_range(0, 4095);
            end
            case ($urandom_range(0, 19))
                0:       count = 13'($urandom_range(0, 8191));
                1:       count = 13'd4096;
                default: count = 13'($urandom_range(0, 64));
            endcase
            send_item(pba_pkg::ACT_FREE, count, addr);
        end else if (sel < 95) begin
            send_item(pba_pkg::ACT_QUERY, 13'($urandom_range(0, 8191)), addr);
        end else begin
            send_item(ACT_NONE, 13'($urandom_range(0, 8191)), addr);
        end
    endtask

    initial begin
        logic [31:0] bases [5];
        aresetn      = 1'b0;
        cfg_we       = 1'b0;
        cfg_wdata    = '0;
        s_valid      = 1'b0;
        s_action     = pba_pkg::ACT_ALLOC;
        s_page_count = '0;
        s_address    = '0;
        tx_idle_pct  = 21;
        rx_idle_pct  = 76;
        heap_base    = pba_pkg::HEAP_BASE_RST;
        repeat (6) @(negedge aclk);
        aresetn = 1'b1;

        // Directed pass over the special cases at the reset heap base.
        send_item(pba_pkg::ACT_QUERY, 13'd0, 32'h0);
        send_item(pba_pkg::ACT_ALLOC, 13'd0, 32'h0);
        send_item(pba_pkg::ACT_ALLOC, 13'd1, 32'hFFFF_FFFF);
        send_item(pba_pkg::ACT_ALLOC, 13'd4096, 32'h0);
        send_item(pba_pkg::ACT_ALLOC, 13'd8191, 32'h0);
        send_item(pba_pkg::ACT_ALLOC, 13'd3, 32'h0);
        send_item(pba_pkg::ACT_FREE, 13'd1, heap_base);
        send_item(pba_pkg::ACT_FREE, 13'd1, heap_base);
        send_item(pba_pkg::ACT_FREE, 13'd0, heap_base + 32'h1000);
        send_item(pba_pkg::ACT_FREE, 13'd1, heap_base - 32'd1);
        send_item(pba_pkg::ACT_FREE, 13'd1,
                  heap_base + (32'd4096 << pba_pkg::PAGE_SHIFT_DEF));
        send_item(pba_pkg::ACT_FREE, 13'd1, 32'hFFFF_FFFF);
        send_item(pba_pkg::ACT_FREE, 13'd8191, heap_base + 32'h1FFF);
        send_item(pba_pkg::ACT_ALLOC, 13'd4096, 32'h0);
        send_item(pba_pkg::ACT_QUERY, 13'd8191, 32'hFFFF_FFFF);
        send_item(pba_pkg::ACT_ALLOC, 13'd1, 32'h0);
        send_item(pba_pkg::ACT_FREE, 13'd100,
                  heap_base + (32'd4090 << pba_pkg::PAGE_SHIFT_DEF));
        send_item(pba_pkg::ACT_ALLOC, 13'd7, 32'h0);
        send_item(pba_pkg::ACT_QUERY, 13'd0, 32'h0);
        send_item(pba_pkg::ACT_FREE, 13'd8191, heap_base);
        send_item(ACT_NONE, 13'd8191, 32'hFFFF_FFFF);
        send_item(pba_pkg::ACT_QUERY, 13'd0, 32'h0);

        // Random traffic over several heap bases, including the extremes.
        bases[0] = 32'h0000_0000;
        bases[1] = 32'hFFFF_F000;
        bases[2] = 32'hFFFF_FFFF;
        bases[3] = $urandom & 32'hFFFF_F000;
        bases[4] = pba_pkg::HEAP_BASE_RST;
        for (int n = 0; n < RAND_ITEMS; n++) begin
            if (n % (RAND_ITEMS / 5) == 0)
                set_heap_base(bases[n / (RAND_ITEMS / 5)]);
            if (n == RAND_ITEMS / 3) begin
                tx_idle_pct = 76;
                rx_idle_pct = 21;
            end else if (n == 2 * RAND_ITEMS / 3) begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end
            send_random_item();
        end
        s_valid <= 1'b0;

        // Drain and settle.
        while (pending != 0)
            @(negedge aclk);
        repeat (50) @(negedge aclk);
        if (fail_count == 0) begin
            $display("page_bitmap_allocator_top regression: pass");
        end else begin
            $display("page_bitmap_allocator_top regression: fail");
        end
        $finish;
    end

endmodule
